// ===== hw/rtl/ist_pkg.sv =====
// Interval set table: shared codes and the cell control struct.
// No dependencies; used by ist_cell and interval_set_table_core.
`default_nettype none
package ist_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic shift;
        logic wa_en;
        logic wb_en;
    } ist_cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ist_cell.sv =====
// One interval slot of the chain: shifts toward the head or loads from a write port.
// Depends on ist_pkg (ist_cell_ctl_t).
`default_nettype none
module ist_cell #(
    parameter int COORD_BITS = 32,
    parameter int IDX_BITS   = 7,
    parameter int INDEX      = 0
) (
    input  wire                      clk,
    input  ist_pkg::ist_cell_ctl_t   ctl,
    input  wire [IDX_BITS-1:0]       wa_idx,
    input  wire [COORD_BITS-1:0]     wa_s,
    input  wire [COORD_BITS-1:0]     wa_e,
    input  wire [IDX_BITS-1:0]       wb_idx,
    input  wire [COORD_BITS-1:0]     wb_s,
    input  wire [COORD_BITS-1:0]     wb_e,
    input  wire [COORD_BITS-1:0]     nbr_s,
    input  wire [COORD_BITS-1:0]     nbr_e,
    output logic [COORD_BITS-1:0]    s,
    output logic [COORD_BITS-1:0]    e
);

    localparam logic [IDX_BITS-1:0] MyIdx = IDX_BITS'(INDEX);

    logic [COORD_BITS-1:0] s_reg, e_reg, s_next, e_next;

    always_comb
    begin
        s_next = s_reg;
        e_next = e_reg;
        if (ctl.wa_en && wa_idx == MyIdx)
        begin
            s_next = wa_s;
            e_next = wa_e;
        end
        else if (ctl.wb_en && wb_idx == MyIdx)
        begin
            s_next = wb_s;
            e_next = wb_e;
        end
        else if (ctl.shift)
        begin
            s_next = nbr_s;
            e_next = nbr_e;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        e_reg <= e_next;
    end

    assign s = s_reg;
    assign e = e_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/interval_set_table_core.sv =====
// Interval set table top level: control sequencer, interval update unit, cell chain.
// Depends on ist_pkg and ist_cell.
`default_nettype none
// An item is taken when start is high and busy is low. The stored intervals sit in a chain
// of cells that rotates one entry toward the head per cycle. An item walks the chain in
// up to two passes: a counting pass that sizes the new table (and answers a query), then,
// for an accepted add or remove, a rewrite pass that pops each entry and appends its
// successors at the tail. An empty range or an empty table needs no pass. No new item is
// taken until the last one is through. The result is on covered, status and entries_used
// for the single cycle in which done is high; it must be taken then.
module interval_set_table_core #(
    parameter int COORD_BITS    = 32,
    parameter int MAX_INTERVALS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  mode,
    input  wire  [31:0] range_start,
    input  wire  [31:0] range_end,
    output logic        done,
    output logic        covered,
    output logic [1:0]  status,
    output logic [6:0]  entries_used
);

    localparam int NCELLS = MAX_INTERVALS + 1;
    localparam int CW     = $clog2(MAX_INTERVALS + 2);
    localparam int UW     = $clog2(MAX_INTERVALS + 1);
    localparam int NW     = $clog2(2 * MAX_INTERVALS + 4);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FIN1  = 5'b00100,
        S_APPLY = 5'b01000,
        S_FIN2  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [CW-1:0] k_reg, k_next, tot_reg, tot_next;
    logic [NW-1:0] n_reg, n_next;
    logic [1:0] mode_reg, mode_next;
    logic [COORD_BITS-1:0] l_reg, l_next, r_reg, r_next;
    logic [COORD_BITS-1:0] ms_reg, ms_next, me_reg, me_next;
    logic placed_reg, placed_next, cov_reg, cov_next;
    logic done_reg, done_next;
    logic [1:0] status_reg, status_next;
    logic covered_reg, covered_next;

    logic [COORD_BITS-1:0] cell_s [NCELLS];
    logic [COORD_BITS-1:0] cell_e [NCELLS];
    ist_pkg::ist_cell_ctl_t ctl;
    logic [CW-1:0] wa_idx, wb_idx;
    logic [COORD_BITS-1:0] wa_s, wa_e, wb_s, wb_e;

    // update unit on the head entry
    logic [COORD_BITS-1:0] hs, he, a_in, b_in;
    logic [1:0] em_cnt;
    logic [COORD_BITS-1:0] em0_s, em0_e, em1_s, em1_e;
    logic st_placed;
    logic [COORD_BITS-1:0] st_ms, st_me;
    logic is_before, is_after, lo_part, hi_part, last_step;

    assign hs   = cell_s[0];
    assign he   = cell_e[0];
    assign a_in = COORD_BITS'(range_start);
    assign b_in = COORD_BITS'(range_end);

    always_comb
    begin
        em_cnt    = 2'd0;
        em0_s     = hs;
        em0_e     = he;
        em1_s     = hs;
        em1_e     = he;
        st_placed = placed_reg;
        st_ms     = ms_reg;
        st_me     = me_reg;
        is_before = (l_reg != '0) && (he < l_reg - 1'b1);
        is_after  = (r_reg != '1) && (hs > r_reg + 1'b1);
        lo_part   = hs < l_reg;
        hi_part   = he > r_reg;
        if (mode_reg == ist_pkg::MODE_ADD)
        begin
            if (is_before)
            begin
                em_cnt = 2'd1;
            end
            else if (is_after)
            begin
                if (!placed_reg)
                begin
                    em_cnt    = 2'd2;
                    em0_s     = ms_reg;
                    em0_e     = me_reg;
                    st_placed = 1'b1;
                end
                else
                begin
                    em_cnt = 2'd1;
                end
            end
            else
            begin
                if (hs < ms_reg)
                    st_ms = hs;
                if (he > me_reg)
                    st_me = he;
            end
        end
        else if (mode_reg == ist_pkg::MODE_REMOVE)
        begin
            if (he < l_reg || hs > r_reg)
            begin
                em_cnt = 2'd1;
            end
            else
            begin
                em_cnt = {1'b0, lo_part} + {1'b0, hi_part};
                em0_e  = l_reg - 1'b1;
                if (!lo_part)
                begin
                    em0_s = r_reg + 1'b1;
                    em0_e = he;
                end
                em1_s = r_reg + 1'b1;
                em1_e = he;
            end
        end
    end

    assign last_step = (k_reg == CW'(used_reg) - 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        k_next       = k_reg;
        tot_next     = tot_reg;
        n_next       = n_reg;
        mode_next    = mode_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        ms_next      = ms_reg;
        me_next      = me_reg;
        placed_next  = placed_reg;
        cov_next     = cov_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        covered_next = covered_reg;
        ctl          = '0;
        wa_idx       = '0;
        wb_idx       = '0;
        wa_s         = em0_s;
        wa_e         = em0_e;
        wb_s         = em1_s;
        wb_e         = em1_e;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    l_next      = a_in;
                    r_next      = b_in - 1'b1;
                    ms_next     = a_in;
                    me_next     = b_in - 1'b1;
                    placed_next = 1'b0;
                    cov_next    = 1'b0;
                    n_next      = '0;
                    k_next      = '0;
                    if (a_in >= b_in)
                    begin
                        done_next    = 1'b1;
                        status_next  = ist_pkg::ST_EMPTY;
                        covered_next = 1'b0;
                    end
                    else if (used_reg == '0)
                        state_next = S_FIN1;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rotate: head goes back to the tail, table unchanged after a full pass
                ctl.shift   = 1'b1;
                ctl.wa_en   = 1'b1;
                wa_idx      = CW'(used_reg) - 1'b1;
                wa_s        = hs;
                wa_e        = he;
                n_next      = n_reg + NW'(em_cnt);
                placed_next = st_placed;
                ms_next     = st_ms;
                me_next     = st_me;
                if (hs <= l_reg && he >= r_reg)
                    cov_next = 1'b1;
                k_next = k_reg + 1'b1;
                if (last_step)
                    state_next = S_FIN1;
            end
            S_FIN1:
            begin
                if (mode_reg == ist_pkg::MODE_ADD || mode_reg == ist_pkg::MODE_REMOVE)
                begin
                    if ((n_reg + NW'(mode_reg == ist_pkg::MODE_ADD && !placed_reg))
                        > NW'(MAX_INTERVALS))
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        status_next  = ist_pkg::ST_FULL;
                        covered_next = 1'b0;
                    end
                    else
                    begin
                        placed_next = 1'b0;
                        ms_next     = l_reg;
                        me_next     = r_reg;
                        k_next      = '0;
                        tot_next    = CW'(used_reg);
                        state_next  = (used_reg == '0) ? S_FIN2 : S_APPLY;
                    end
                end
                else
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    status_next  = ist_pkg::ST_OK;
                    covered_next = (mode_reg == ist_pkg::MODE_QUERY) && cov_reg;
                end
            end
            S_APPLY:
            begin
                // pop the head, append its successors behind the remaining entries
                ctl.shift   = 1'b1;
                ctl.wa_en   = em_cnt != 2'd0;
                ctl.wb_en   = em_cnt == 2'd2;
                wa_idx      = tot_reg - 1'b1;
                wb_idx      = tot_reg;
                tot_next    = tot_reg - 1'b1 + CW'(em_cnt);
                placed_next = st_placed;
                ms_next     = st_ms;
                me_next     = st_me;
                k_next      = k_reg + 1'b1;
                if (last_step)
                    state_next = S_FIN2;
            end
            S_FIN2:
            begin
                ctl.wa_en = (mode_reg == ist_pkg::MODE_ADD) && !placed_reg;
                wa_idx    = tot_reg;
                wa_s      = ms_reg;
                wa_e      = me_reg;
                used_next = UW'(tot_reg + CW'(ctl.wa_en));
                state_next   = S_IDLE;
                done_next    = 1'b1;
                status_next  = ist_pkg::ST_OK;
                covered_next = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        tot_reg     <= tot_next;
        n_reg       <= n_next;
        mode_reg    <= mode_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        ms_reg      <= ms_next;
        me_reg      <= me_next;
        placed_reg  <= placed_next;
        cov_reg     <= cov_next;
        status_reg  <= status_next;
        covered_reg <= covered_next;
    end

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        localparam int NB = (i == NCELLS - 1) ? i : i + 1;
        ist_cell #(
            .COORD_BITS(COORD_BITS),
            .IDX_BITS  (CW),
            .INDEX     (i)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .wa_idx(wa_idx),
            .wa_s  (wa_s),
            .wa_e  (wa_e),
            .wb_idx(wb_idx),
            .wb_s  (wb_s),
            .wb_e  (wb_e),
            .nbr_s (cell_s[NB]),
            .nbr_e (cell_e[NB]),
            .s     (cell_s[i]),
            .e     (cell_e[i])
        );
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign covered      = covered_reg;
    assign status       = status_reg;
    assign entries_used = 7'(used_reg);

endmodule
`default_nettype wire

// ===== tb/sv/tb_interval_set_table_core.sv =====
// Testbench for interval_set_table_core: random and directed add/remove/query items,
// checked against an in-bench interval table model. Depends on ist_pkg and the core RTL.
`default_nettype none
module tb_interval_set_table_core;

    localparam int MAX_IV = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] lo;
        logic [31:0] hi;
        bit          drain;   // hold off until all results are in
    } item_t;

    typedef struct {
        logic       covered;
        logic [1:0] status;
        logic [6:0] used;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [1:0]  mode;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic        busy;
    logic        done;
    logic        covered;
    logic [1:0]  status;
    logic [6:0]  entries_used;

    interval_set_table_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .range_start(range_start), .range_end(range_end), .done(done),
        .covered(covered), .status(status), .entries_used(entries_used)
    );

    // table model
    logic [31:0] iv_lo[$];
    logic [31:0] iv_hi[$];

    item_t    pending_items[$];
    outcome_t expected_outcomes[$];
    int       errors = 0;
    int       n_items = 0;
    int       n_results = 0;
    int       n_full = 0;
    int       n_cover = 0;
    bit       stim_done = 0;
    bit       quiet_tail = 0;
    int       idle_cycles = 0;
    bit       acc_seen = 0;   // item on the ports was taken at the last rising edge

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic outcome_t apply_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        outcome_t    res;
        logic [31:0] nl[$];
        logic [31:0] nh[$];
        logic [31:0] r;
        logic [31:0] ms;
        logic [31:0] me;
        logic [31:0] s;
        logic [31:0] e;
        bit          placed;
        bit          commit;
        res.covered = 1'b0;
        res.status = ist_pkg::ST_OK;
        commit = 0;
        placed = 0;
        if (a >= b)
        begin
            res.status = ist_pkg::ST_EMPTY;
        end
        else
        begin
            r = b - 1;
            if (op == ist_pkg::MODE_ADD)
            begin
                ms = a;
                me = r;
                foreach (iv_lo[i])
                begin
                    s = iv_lo[i];
                    e = iv_hi[i];
                    if (a > 0 && e < a - 1)
                    begin
                        nl.push_back(s);
                        nh.push_back(e);
                    end
                    else if (r != 32'hFFFF_FFFF && s > r + 1)
                    begin
                        if (!placed)
                        begin
                            nl.push_back(ms);
                            nh.push_back(me);
                            placed = 1;
                        end
                        nl.push_back(s);
                        nh.push_back(e);
                    end
                    else
                    begin
                        if (s < ms) ms = s;
                        if (e > me) me = e;
                    end
                end
                if (!placed)
                begin
                    nl.push_back(ms);
                    nh.push_back(me);
                end
                commit = 1;
            end
            else if (op == ist_pkg::MODE_REMOVE)
            begin
                foreach (iv_lo[i])
                begin
                    s = iv_lo[i];
                    e = iv_hi[i];
                    if (e < a || s > r)
                    begin
                        nl.push_back(s);
                        nh.push_back(e);
                    end
                    else
                    begin
                        if (s < a)
                        begin
                            nl.push_back(s);
                            nh.push_back(a - 1);
                        end
                        if (e > r)
                        begin
                            nl.push_back(r + 1);
                            nh.push_back(e);
                        end
                    end
                end
                commit = 1;
            end
            else if (op == ist_pkg::MODE_QUERY)
            begin
                foreach (iv_lo[i])
                    if (iv_lo[i] <= a && iv_hi[i] >= r)
                        res.covered = 1'b1;
            end
            if (commit)
            begin
                if (nl.size() > MAX_IV)
                begin
                    res.status = ist_pkg::ST_FULL;
                end
                else
                begin
                    iv_lo = nl;
                    iv_hi = nh;
                end
            end
        end
        res.used = 7'(iv_lo.size());
        return res;
    endfunction

    // coordinates clustered in a small window so ranges collide often
    function automatic logic [31:0] pick_coord(logic [31:0] base, int span);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return base + $urandom_range(0, span);
        endcase
    endfunction

    task automatic queue_item(logic [1:0] op, logic [31:0] a, logic [31:0] b, bit drain = 0);
        item_t it;
        it.mode = op;
        it.lo = a;
        it.hi = b;
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    initial
    begin
        logic [31:0] base;
        logic [31:0] a;
        logic [31:0] w;
        int          span;
        int          fill;
        // directed: empties, extremes, every mode, adjacency, split, unused mode
        queue_item(ist_pkg::MODE_QUERY, 0, 1);
        queue_item(ist_pkg::MODE_ADD, 5, 5);
        queue_item(ist_pkg::MODE_REMOVE, 9, 3);
        queue_item(ist_pkg::MODE_ADD, 0, 32'hFFFF_FFFF);
        queue_item(ist_pkg::MODE_QUERY, 0, 32'hFFFF_FFFF);
        queue_item(ist_pkg::MODE_REMOVE, 100, 200);
        queue_item(ist_pkg::MODE_QUERY, 0, 100);
        queue_item(ist_pkg::MODE_QUERY, 99, 101);
        queue_item(ist_pkg::MODE_ADD, 100, 150);
        queue_item(ist_pkg::MODE_ADD, 150, 200);
        queue_item(ist_pkg::MODE_QUERY, 0, 32'hFFFF_FFFF);
        queue_item(ist_pkg::MODE_REMOVE, 0, 32'hFFFF_FFFF);
        queue_item(MODE_UNUSED, 1, 2);
        queue_item(MODE_UNUSED, 2, 2);
        queue_item(ist_pkg::MODE_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1);
        queue_item(ist_pkg::MODE_ADD, 10, 20);
        queue_item(ist_pkg::MODE_ADD, 30, 40);
        queue_item(ist_pkg::MODE_ADD, 20, 30);
        queue_item(ist_pkg::MODE_QUERY, 10, 40);
        queue_item(ist_pkg::MODE_REMOVE, 15, 16);
        queue_item(ist_pkg::MODE_QUERY, 10, 40);
        queue_item(ist_pkg::MODE_QUERY, 16, 40);
        queue_item(ist_pkg::MODE_REMOVE, 0, 32'hFFFF_FFFF);
        // fill the table to the limit with isolated points, then overflow it
        for (int i = 0; i < MAX_IV; i++)
            queue_item(ist_pkg::MODE_ADD, 1000 + 2 * i, 1001 + 2 * i);
        queue_item(ist_pkg::MODE_ADD, 5000, 5001);
        queue_item(ist_pkg::MODE_REMOVE, 1002, 1003);
        queue_item(ist_pkg::MODE_ADD, 1002, 1003);
        queue_item(ist_pkg::MODE_REMOVE, 1010, 1011);   // removes one isolated point
        queue_item(ist_pkg::MODE_REMOVE, 1000, 1001);
        queue_item(ist_pkg::MODE_ADD, 7000, 7001);
        queue_item(ist_pkg::MODE_REMOVE, 1020, 1021);   // splits nothing; points are single
        queue_item(ist_pkg::MODE_ADD, 1000, 1001);
        queue_item(ist_pkg::MODE_ADD, 1000, 1003);      // merge two
        queue_item(ist_pkg::MODE_REMOVE, 1000, 1001);
        queue_item(ist_pkg::MODE_REMOVE, 1050, 1051, 1);
        queue_item(ist_pkg::MODE_REMOVE, 0, 32'hFFFF_FFFF);
        // random phases: each picks a window; sometimes builds up a near full table
        while (pending_items.size() < 1890)
        begin
            base = $urandom;
            span = ($urandom_range(0, 3) == 0) ? 40 : 400;
            if ($urandom_range(0, 5) == 0)
            begin
                fill = $urandom_range(55, 66);
                for (int i = 0; i < fill; i++)
                    queue_item(ist_pkg::MODE_ADD, base + 4 * i,
                               base + 4 * i + $urandom_range(1, 3));
            end
            for (int i = 0; i < 60; i++)
            begin
                a = pick_coord(base, span);
                if ($urandom_range(0, 15) == 0)
                    w = pick_coord(base, span);
                else
                    w = a + $urandom_range(1, span / 4);
                queue_item(2'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)), a, w,
                           $urandom_range(0, 40) == 0);
            end
            if ($urandom_range(0, 3) == 0)
                queue_item(ist_pkg::MODE_REMOVE, 0, 32'hFFFF_FFFF);
        end
    end

    // driver: inputs change on the falling edge
    int gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !acc_seen)
        begin
            // still waiting for acceptance
        end
        else if (gap > 0)
        begin
            gap <= gap - 1;
            start <= 1'b0;
        end
        else if (pending_items.size() == 0)
        begin
            start <= 1'b0;
            stim_done <= 1'b1;
        end
        else if (pending_items[0].drain && expected_outcomes.size() != 0)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (!quiet_tail && pending_items.size() < 300)
                quiet_tail <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                gap <= $urandom_range(0, 6);
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                mode <= pending_items[0].mode;
                range_start <= pending_items[0].lo;
                range_end <= pending_items[0].hi;
            end
        end
    end

    // acceptance and result check at the rising edge
    always @(posedge clk)
    begin
        outcome_t want;
        int       bad;
        bit       progress;
        bad = 0;
        progress = 1'b0;
        acc_seen <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_outcomes.push_back(apply_item(mode, range_start, range_end));
                void'(pending_items.pop_front());
                n_items <= n_items + 1;
                progress = 1'b1;
            end
            if (done)
            begin
                progress = 1'b1;
                n_results <= n_results + 1;
                if (expected_outcomes.size() == 0)
                begin
                    $error("result with no item outstanding");
                    bad = bad + 1;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (want.status == ist_pkg::ST_FULL) n_full <= n_full + 1;
                    if (want.covered) n_cover <= n_cover + 1;
                    if (covered !== want.covered)
                    begin
                        $error("covered: expected %0d, got %0d", want.covered, covered);
                        bad = bad + 1;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        bad = bad + 1;
                    end
                    if (entries_used !== want.used)
                    begin
                        $error("entries_used: expected %0d, got %0d", want.used, entries_used);
                        bad = bad + 1;
                    end
                end
            end
            idle_cycles <= progress ? 0 : idle_cycles + 1;
            errors <= errors + bad;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = ist_pkg::MODE_ADD;
        range_start = '0;
        range_end = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        fork
            begin
                wait (stim_done && expected_outcomes.size() == 0);
                repeat (2 * MAX_IV + 10) @(posedge clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
            end
        join_any
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
        end
        else
        begin
            $display("%0d items, %0d results; %0d rejected as full, %0d queries covered",
                     n_items, n_results, n_full, n_cover);
            if (errors == 0 && expected_outcomes.size() == 0)
                $display("RESULT: OK");
            else
                $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== interval_set_table_core.f =====
hw/rtl/ist_pkg.sv
hw/rtl/ist_cell.sv
hw/rtl/interval_set_table_core.sv
tb/sv/tb_interval_set_table_core.sv
